@@ hw/rtl/mcrf_pkg.sv @@
package mcrf_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int NUM_MOTORS = 4;
  localparam int CMD_W      = 16;
  localparam int DRV_W      = 15;
  localparam int CFG_IDX_W  = 1;

  // quotient never exceeds the band, so it fits a drive word
  localparam int QUO_W  = DRV_W;
  localparam int PROD_W = CMD_W + DRV_W;
  localparam int REM_W  = PROD_W - QUO_W;

  localparam logic [DRV_W-1:0] ONE_Q = DRV_W'(1) << FRAC_BITS;

  // pipeline: capture, min/max, setup, lane setup, divide steps, lane result
  localparam int ST_DIV0 = 4;
  localparam int NSTG    = ST_DIV0 + QUO_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_REV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REV = 1'b1;

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic [DRV_W-1:0]        drv_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_motor_a;
    logic signed [CMD_W-1:0] cmd_motor_b;
    logic signed [CMD_W-1:0] cmd_motor_c;
    logic signed [CMD_W-1:0] cmd_motor_d;
  } cmd_item_t;

  typedef struct packed {
    logic [DRV_W-1:0] drive_motor_a;
    logic [DRV_W-1:0] drive_motor_b;
    logic [DRV_W-1:0] drive_motor_c;
    logic [DRV_W-1:0] drive_motor_d;
  } drive_item_t;

  // per-item values shared by all lanes
  typedef struct packed {
    logic signed [CMD_W-1:0] vmin;
    logic [CMD_W-1:0]        spread;
    logic [DRV_W-1:0]        band;
    logic signed [CMD_W:0]   off;
    logic                    fits;
    logic [DRV_W-1:0]        lo;
    logic [DRV_W-1:0]        hi;
  } lane_ctl_t;

endpackage

@@ hw/rtl/mcrf_range.sv @@
module mcrf_range (
  input  logic                    clk,
  input  logic                    en,
  input  mcrf_pkg::cmd_t          v_i [mcrf_pkg::NUM_MOTORS],
  input  mcrf_pkg::drv_t          lo_i,
  input  mcrf_pkg::drv_t          hi_i,
  output mcrf_pkg::cmd_t          v_o [mcrf_pkg::NUM_MOTORS],
  output mcrf_pkg::lane_ctl_t     ctl_o
);
  import mcrf_pkg::*;

  cmd_t      v1_r [NUM_MOTORS];
  cmd_t      v2_r [NUM_MOTORS];
  cmd_t      vmin_r, vmax_r;
  cmd_t      vmin_nxt, vmax_nxt;
  drv_t      lo1_r, hi1_r;
  lane_ctl_t ctl_r, ctl_nxt;
  cmd_t      min_ab, min_cd, max_ab, max_cd;

  // two-level compare tree across the lanes
  always_comb begin
    min_ab   = (v_i[1] < v_i[0]) ? v_i[1] : v_i[0];
    min_cd   = (v_i[3] < v_i[2]) ? v_i[3] : v_i[2];
    max_ab   = (v_i[1] > v_i[0]) ? v_i[1] : v_i[0];
    max_cd   = (v_i[3] > v_i[2]) ? v_i[3] : v_i[2];
    vmin_nxt = (min_cd < min_ab) ? min_cd : min_ab;
    vmax_nxt = (max_cd > max_ab) ? max_cd : max_ab;
  end

  always_comb begin
    logic signed [CMD_W:0] lo_s, hi_s, vmin_s, vmax_s;
    lo_s   = $signed({2'b00, lo1_r});
    hi_s   = $signed({2'b00, hi1_r});
    vmin_s = {vmin_r[CMD_W-1], vmin_r};
    vmax_s = {vmax_r[CMD_W-1], vmax_r};
    ctl_nxt.vmin   = vmin_r;
    ctl_nxt.spread = CMD_W'(vmax_s - vmin_s);
    ctl_nxt.band   = hi1_r - lo1_r;
    ctl_nxt.fits   = ({1'b0, ctl_nxt.spread} <= {2'b00, ctl_nxt.band});
    ctl_nxt.lo     = lo1_r;
    ctl_nxt.hi     = hi1_r;
    priority if (vmin_s < lo_s) begin
      ctl_nxt.off = lo_s - vmin_s;
    end else if (vmax_s > hi_s) begin
      ctl_nxt.off = hi_s - vmax_s;
    end else begin
      ctl_nxt.off = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r   <= v_i;
      vmin_r <= vmin_nxt;
      vmax_r <= vmax_nxt;
      lo1_r  <= lo_i;
      hi1_r  <= hi_i;
      v2_r   <= v1_r;
      ctl_r  <= ctl_nxt;
    end
  end

  assign v_o   = v2_r;
  assign ctl_o = ctl_r;

endmodule

@@ hw/rtl/mcrf_lane.sv @@
module mcrf_lane (
  input  logic                clk,
  input  logic                en,
  input  mcrf_pkg::cmd_t      v_i,
  input  mcrf_pkg::lane_ctl_t ctl_i,
  output mcrf_pkg::drv_t      drive_o
);
  import mcrf_pkg::*;

  logic [REM_W-1:0] rem_r  [QUO_W+1];
  logic [QUO_W-1:0] sh_r   [QUO_W+1];
  logic [CMD_W-1:0] spr_r  [QUO_W+1];
  drv_t             lo_r   [QUO_W+1];
  drv_t             hi_r   [QUO_W+1];
  drv_t             rfit_r [QUO_W+1];
  logic             fits_r [QUO_W+1];
  drv_t             drive_r, drive_nxt;

  logic [PROD_W-1:0]   prod_nxt;
  drv_t                rfit_nxt;

  // lane setup: offset path and the scaling product
  always_comb begin
    logic signed [CMD_W:0]   diff;
    logic signed [CMD_W+1:0] sum;
    logic signed [CMD_W+1:0] lo_s, hi_s;
    diff     = {v_i[CMD_W-1], v_i} - {ctl_i.vmin[CMD_W-1], ctl_i.vmin};
    prod_nxt = PROD_W'(diff[CMD_W-1:0]) * PROD_W'(ctl_i.band);
    sum      = {v_i[CMD_W-1], v_i[CMD_W-1], v_i} + {ctl_i.off[CMD_W], ctl_i.off};
    lo_s     = $signed({3'b000, ctl_i.lo});
    hi_s     = $signed({3'b000, ctl_i.hi});
    priority if (sum < lo_s) begin
      rfit_nxt = ctl_i.lo;
    end else if (sum > hi_s) begin
      rfit_nxt = ctl_i.hi;
    end else begin
      rfit_nxt = sum[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= prod_nxt[PROD_W-1:QUO_W];
      sh_r[0]   <= prod_nxt[QUO_W-1:0];
      spr_r[0]  <= ctl_i.spread;
      lo_r[0]   <= ctl_i.lo;
      hi_r[0]   <= ctl_i.hi;
      rfit_r[0] <= rfit_nxt;
      fits_r[0] <= ctl_i.fits;
    end
  end

  // one restoring step per stage; quotient bits shift in behind the dividend
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[j], sh_r[j][QUO_W-1]};
      ge      = (trial >= {1'b0, spr_r[j]});
      rem_nxt = ge ? REM_W'(trial - {1'b0, spr_r[j]}) : trial[REM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= rem_nxt;
        sh_r[j+1]   <= {sh_r[j][QUO_W-2:0], ge};
        spr_r[j+1]  <= spr_r[j];
        lo_r[j+1]   <= lo_r[j];
        hi_r[j+1]   <= hi_r[j];
        rfit_r[j+1] <= rfit_r[j];
        fits_r[j+1] <= fits_r[j];
      end
    end
  end

  always_comb begin
    logic [DRV_W:0] scaled;
    scaled = {1'b0, lo_r[QUO_W]} + {1'b0, sh_r[QUO_W]};
    priority if (fits_r[QUO_W]) begin
      drive_nxt = rfit_r[QUO_W];
    end else if (scaled > {1'b0, hi_r[QUO_W]}) begin
      drive_nxt = hi_r[QUO_W];
    end else if (scaled < {1'b0, lo_r[QUO_W]}) begin
      drive_nxt = lo_r[QUO_W];
    end else begin
      drive_nxt = scaled[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive_o = drive_r;

endmodule

@@ hw/rtl/motor_command_range_fit.sv @@
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+--------------------------------------
// in       | in  | in_valid/in_stall  | in_item  (four signed Q2.14 commands)
// out      | out | out_valid/out_stall| out_item (four fitted drives, Q1.14)
// cfg      | in  | cfg_we             | cfg_index, cfg_wdata (min_rev, max_rev)
//
// One item per cycle while in_stall is low, over 21 register stages: capture,
// min/max, band setup, lane product, 15 quotient steps of the per-lane divider,
// lane result, output reg.
// rst_n (sync, active low) clears the valid bits and the skid entry, and sets
// the band to 0..ONE_Q. A stalled result parks the next one in a skid entry;
// the pipe holds and in_stall rises only while that entry is full.
module motor_command_range_fit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mcrf_pkg::cmd_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mcrf_pkg::drive_item_t               out_item,
  input  logic                                cfg_we,
  input  logic [mcrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcrf_pkg::DRV_W-1:0]          cfg_wdata
);
  import mcrf_pkg::*;

  drv_t        min_rev_r, max_rev_r;
  logic [NSTG-1:0] vld_r;
  logic        en;
  cmd_t        v0_r [NUM_MOTORS];
  drv_t        lo0_r, hi0_r;
  drv_t        lo_nxt, hi_nxt;
  cmd_t        v2 [NUM_MOTORS];
  lane_ctl_t   ctl2;
  drv_t        drv_pipe [NUM_MOTORS];
  drive_item_t pipe_item;
  drive_item_t out_item_r, skid_item_r;
  logic        out_vld_r, skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rev_r <= '0;
      max_rev_r <= ONE_Q;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_REV: min_rev_r <= cfg_wdata;
        REG_MAX_REV: max_rev_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to full speed; an inverted band collapses onto min_rev
  always_comb begin
    lo_nxt = (min_rev_r > ONE_Q) ? ONE_Q : min_rev_r;
    hi_nxt = (max_rev_r > ONE_Q) ? ONE_Q : max_rev_r;
    if (hi_nxt < lo_nxt) begin
      hi_nxt = lo_nxt;
    end
  end

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r[0] <= in_item.cmd_motor_a;
      v0_r[1] <= in_item.cmd_motor_b;
      v0_r[2] <= in_item.cmd_motor_c;
      v0_r[3] <= in_item.cmd_motor_d;
      lo0_r   <= lo_nxt;
      hi0_r   <= hi_nxt;
    end
  end

  mcrf_range u_range (
    .clk   (clk),
    .en    (en),
    .v_i   (v0_r),
    .lo_i  (lo0_r),
    .hi_i  (hi0_r),
    .v_o   (v2),
    .ctl_o (ctl2)
  );

  for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
    mcrf_lane u_lane (
      .clk     (clk),
      .en      (en),
      .v_i     (v2[i]),
      .ctl_i   (ctl2),
      .drive_o (drv_pipe[i])
    );
  end

  assign pipe_item.drive_motor_a = drv_pipe[0];
  assign pipe_item.drive_motor_b = drv_pipe[1];
  assign pipe_item.drive_motor_c = drv_pipe[2];
  assign pipe_item.drive_motor_d = drv_pipe[3];

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (!out_stall) begin
        skid_vld_r <= 1'b0;
      end
    end else if (out_vld_r && out_stall) begin
      skid_vld_r <= vld_r[NSTG-1];
    end else begin
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (!out_stall) begin
        out_item_r <= skid_item_r;
      end
    end else if (out_vld_r && out_stall) begin
      skid_item_r <= pipe_item;
    end else begin
      out_item_r <= pipe_item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/mcrf_checker.sv @@
module mcrf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input mcrf_pkg::cmd_item_t            in_item,
  input logic                           out_valid,
  input logic                           out_stall,
  input mcrf_pkg::drive_item_t          out_item,
  input logic                           cfg_we,
  input logic [mcrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mcrf_pkg::DRV_W-1:0]     cfg_wdata
);
  import mcrf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed or dropped");

  a_drive_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.drive_motor_a <= ONE_Q && out_item.drive_motor_b <= ONE_Q
                  && out_item.drive_motor_c <= ONE_Q && out_item.drive_motor_d <= ONE_Q)
    else $error("drive above full speed");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_stall_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a waiting item");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left an item pending");

endmodule

bind motor_command_range_fit mcrf_checker u_mcrf_checker (.*);
